// ===== rtl/rpfp_pkg.sv =====
// Shared types and constants of the request packet field parser.
// Depends on nothing; every other file but rpfp_stream_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package rpfp_pkg;

  localparam logic [7:0]  CFG_MAX_FIELD_LENGTH = 8'd0;
  localparam logic [7:0]  CFG_MAX_OPCODE       = 8'd1;
  localparam logic [31:0] MAX_FIELD_LENGTH_RST = 32'd4096;
  localparam logic [7:0]  MAX_OPCODE_RST       = 8'd9;

  typedef enum logic [2:0] {
    REGION_HEADER   = 3'd0,
    REGION_NAME     = 3'd1,
    REGION_FIRST    = 3'd2,
    REGION_TRAILING = 3'd3,
    REGION_DISCARD  = 3'd4
  } region_e;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_BAD_OPCODE   = 3'd1,
    STATUS_NAME_LONG    = 3'd2,
    STATUS_BAD_TYPE     = 3'd3,
    STATUS_PAYLOAD_LONG = 3'd4,
    STATUS_LEN_MISMATCH = 3'd5
  } status_e;

  typedef enum logic [8:0] {
    PH_TOTAL   = 9'b000000001,
    PH_OPCODE  = 9'b000000010,
    PH_NAMELEN = 9'b000000100,
    PH_NAME    = 9'b000001000,
    PH_TYPE    = 9'b000010000,
    PH_P1LEN   = 9'b000100000,
    PH_P1      = 9'b001000000,
    PH_REST    = 9'b010000000,
    PH_DISCARD = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    region_e     region;
    logic        report_valid;
    status_e     status;
    logic [7:0]  opcode;
    logic [31:0] name_length;
    logic        two_payloads;
    logic [31:0] first_length;
    logic [31:0] rest_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [31:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       type_bad;
    logic       opcode_bad;
  } q_item_t;

endpackage

`default_nettype wire

// ===== rtl/rpfp_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per transaction.
// Used for the byte input, the result output and the configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface rpfp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpfp_queue.sv =====
// Front end: accepts input bytes, classifies type and opcode values, and
// holds them in a two-entry queue. Depends on rpfp_pkg and rpfp_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module rpfp_queue
  import rpfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] max_opcode_i,
  rpfp_stream_if.sink     in_i,
  output      logic       q_valid_o,
  output      q_item_t    q_item_o,
  input  wire logic       q_pop_i
);

  q_item_t    entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       push;
  q_item_t    push_item;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    push_item.data_byte  = in_i.data.data_byte;
    push_item.is_last    = in_i.data.is_last;
    push_item.type_bad   = (in_i.data.data_byte > 8'd1);
    push_item.opcode_bad = (in_i.data.data_byte > max_opcode_i);
  end

  assign cnt_d     = 2'(cnt_q + 2'(push) - 2'(q_pop_i));
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpfp_back.sv =====
// Back end: packet parse state machine, length checks and the result
// register. Depends on rpfp_pkg and rpfp_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module rpfp_back
  import rpfp_pkg::*;
#(
  parameter int LENGTH_BITS      = 32,
  parameter int SIZE_FIELD_BYTES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] max_field_length_i,
  input  wire logic        q_valid_i,
  input  wire q_item_t     q_item_i,
  output      logic        q_pop_o,
  rpfp_stream_if.source    out_o
);

  localparam int LW    = LENGTH_BITS;
  localparam int FW    = 8 * SIZE_FIELD_BYTES;
  localparam int CW    = (LENGTH_BITS > 32) ? LENGTH_BITS : 33;
  localparam int CNT_W = $clog2(SIZE_FIELD_BYTES);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      off_q, off_d;
  logic [LW-1:0]    total_q, total_d;
  logic [FW-1:0]    shift_q, shift_d;
  logic [7:0]       opc_q, opc_d;
  logic [LW-1:0]    name_len_q, name_len_d;
  logic             type_q, type_d;
  logic [LW-1:0]    first_len_q, first_len_d;
  logic [LW-1:0]    rem_q, rem_d;
  status_e          err_q, err_d;

  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        res;

  logic [FW-1:0]    shift_nx;
  logic [63:0]      field64;
  logic [LW-1:0]    field_v;
  logic             field_phase;
  logic             field_done;
  logic             too_big;
  logic [CW-1:0]    nxt;
  logic [CW-1:0]    left;
  logic             over_max;
  logic             over_left;
  region_e          region;
  status_e          st;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign field_phase = (phase_q == PH_TOTAL) || (phase_q == PH_NAMELEN) ||
                       (phase_q == PH_P1LEN);
  assign shift_nx    = shift_q | (FW'(q_item_i.data_byte) << {cnt_q, 3'b000});
  assign field64     = 64'(shift_nx);
  assign field_v     = LW'(field64);
  assign field_done  = (cnt_q == CNT_W'(SIZE_FIELD_BYTES - 1));
  assign too_big     = ((field64 >> LENGTH_BITS) != 64'd0);
  assign nxt         = CW'(off_q) + CW'(1);
  assign left        = (CW'(total_q) > nxt) ? (CW'(total_q) - nxt) : '0;
  assign over_max    = (CW'(field_v) > CW'(max_field_length_i));
  assign over_left   = (CW'(field_v) >= left);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    total_d     = total_q;
    shift_d     = shift_q;
    opc_d       = opc_q;
    name_len_d  = name_len_q;
    type_d      = type_q;
    first_len_d = first_len_q;
    rem_d       = rem_q;
    err_d       = err_q;
    region      = REGION_HEADER;
    st          = STATUS_OK;
    res         = '0;

    if (field_phase) begin
      if (field_done) begin
        shift_d = '0;
        cnt_d   = '0;
      end else begin
        shift_d = shift_nx;
        cnt_d   = CNT_W'(cnt_q + CNT_W'(1));
      end
    end

    unique case (phase_q)
      PH_TOTAL: begin
        if (field_done) begin
          if (too_big) begin
            err_d   = STATUS_LEN_MISMATCH;
            phase_d = PH_DISCARD;
          end else begin
            total_d = field_v;
            phase_d = PH_OPCODE;
          end
        end
      end
      PH_OPCODE: begin
        opc_d = q_item_i.data_byte;
        if (q_item_i.opcode_bad) begin
          if (err_q == STATUS_OK) err_d = STATUS_BAD_OPCODE;
          phase_d = PH_DISCARD;
        end else begin
          phase_d = PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        if (field_done) begin
          if (too_big) begin
            if (err_q == STATUS_OK) err_d = STATUS_LEN_MISMATCH;
            phase_d = PH_DISCARD;
          end else begin
            name_len_d = field_v;
            if (over_max || over_left) begin
              if (err_q == STATUS_OK) err_d = STATUS_NAME_LONG;
              phase_d = PH_DISCARD;
            end else begin
              rem_d   = field_v;
              phase_d = (field_v == '0) ? PH_TYPE : PH_NAME;
            end
          end
        end
      end
      PH_NAME: begin
        region = REGION_NAME;
        if (rem_q != '0) rem_d = LW'(rem_q - LW'(1));
        if (rem_d == '0) phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        if (q_item_i.type_bad) begin
          if (err_q == STATUS_OK) err_d = STATUS_BAD_TYPE;
          phase_d = PH_DISCARD;
        end else begin
          type_d = q_item_i.data_byte[0];
          if (q_item_i.data_byte[0]) begin
            phase_d = PH_P1LEN;
          end else begin
            rem_d   = LW'(left);
            phase_d = PH_REST;
          end
        end
      end
      PH_P1LEN: begin
        if (field_done) begin
          if (too_big) begin
            if (err_q == STATUS_OK) err_d = STATUS_LEN_MISMATCH;
            phase_d = PH_DISCARD;
          end else begin
            first_len_d = field_v;
            if (over_max || over_left) begin
              if (err_q == STATUS_OK) err_d = STATUS_PAYLOAD_LONG;
              phase_d = PH_DISCARD;
            end else if (field_v == '0) begin
              rem_d   = LW'(left);
              phase_d = PH_REST;
            end else begin
              rem_d   = field_v;
              phase_d = PH_P1;
            end
          end
        end
      end
      PH_P1: begin
        region = REGION_FIRST;
        if (rem_q != '0) rem_d = LW'(rem_q - LW'(1));
        if (rem_d == '0) begin
          rem_d   = LW'(left);
          phase_d = PH_REST;
        end
      end
      PH_REST: begin
        region = REGION_TRAILING;
      end
      default: begin
        region = REGION_DISCARD;
      end
    endcase

    res.out_byte = q_item_i.data_byte;
    res.region   = region;

    if (q_item_i.is_last) begin
      st = err_d;
      if ((st == STATUS_OK) && ((phase_d != PH_REST) || (nxt != CW'(total_d)))) begin
        st = STATUS_LEN_MISMATCH;
      end
      res.report_valid = 1'b1;
      res.status       = st;
      res.opcode       = opc_d;
      res.name_length  = 32'(name_len_d);
      res.two_payloads = type_d;
      res.first_length = 32'(first_len_d);
      res.rest_length  = (phase_d == PH_REST) ? 32'(rem_d) : 32'd0;

      phase_d     = PH_TOTAL;
      cnt_d       = '0;
      off_d       = '0;
      total_d     = '0;
      shift_d     = '0;
      opc_d       = '0;
      name_len_d  = '0;
      type_d      = 1'b0;
      first_len_d = '0;
      rem_d       = '0;
      err_d       = STATUS_OK;
    end else if (off_q != '1) begin
      off_d = off_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_d_reset: begin
        phase_q     <= PH_TOTAL;
        cnt_q       <= '0;
        off_q       <= '0;
        total_q     <= '0;
        shift_q     <= '0;
        opc_q       <= '0;
        name_len_q  <= '0;
        type_q      <= 1'b0;
        first_len_q <= '0;
        rem_q       <= '0;
        err_q       <= STATUS_OK;
        out_valid_q <= 1'b0;
      end
    end else begin
      if (q_pop_o) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        off_q       <= off_d;
        total_q     <= total_d;
        shift_q     <= shift_d;
        opc_q       <= opc_d;
        name_len_q  <= name_len_d;
        type_q      <= type_d;
        first_len_q <= first_len_d;
        rem_q       <= rem_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/request_packet_field_parser_core.sv =====
// Request packet field parser. Takes one packet byte per transaction and
// returns one result per byte: the byte, its region tag and, on the last
// byte, the status and the parsed opcode, lengths and type. Sustained rate
// is one byte per clock while results are taken; each byte passes a
// two-entry input queue and then the result register before its result
// is on the output. The length compares are combinational and the parse
// state advances as each byte leaves the queue.
// Configuration writes (0: max field length, 1: max opcode) are always
// ready; other register indexes are ignored. Uses rpfp_pkg, rpfp_stream_if,
// rpfp_queue and rpfp_back.
`timescale 1ns / 1ps
`default_nettype none

module request_packet_field_parser_core
  import rpfp_pkg::*;
#(
  parameter int LENGTH_BITS      = 32,
  parameter int SIZE_FIELD_BYTES = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rpfp_stream_if.sink   in_i,
  rpfp_stream_if.sink   cfg_i,
  rpfp_stream_if.source out_o
);

  logic [31:0] max_len_q;
  logic [7:0]  max_op_q;
  logic        q_valid;
  q_item_t     q_item;
  logic        q_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_FIELD_LENGTH_RST;
      max_op_q  <= MAX_OPCODE_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.addr == CFG_MAX_FIELD_LENGTH) begin
        max_len_q <= cfg_i.data.value;
      end else if (cfg_i.data.addr == CFG_MAX_OPCODE) begin
        max_op_q <= cfg_i.data.value[7:0];
      end
    end
  end

  rpfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_opcode_i (max_op_q),
    .in_i         (in_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  rpfp_back #(
    .LENGTH_BITS      (LENGTH_BITS),
    .SIZE_FIELD_BYTES (SIZE_FIELD_BYTES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .max_field_length_i (max_len_q),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .out_o              (out_o)
  );

`ifndef ASSERT_OFF
  a_quiet_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.report_valid) |->
      (out_o.data.status == STATUS_OK && out_o.data.opcode == 8'd0 &&
       out_o.data.name_length == 32'd0 && out_o.data.rest_length == 32'd0))
    else $error("result without report carries parsed fields");

  a_single_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.report_valid && !out_o.data.two_payloads) |->
      (out_o.data.first_length == 32'd0))
    else $error("first length reported for a single payload packet");

  a_discard_has_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.report_valid &&
     out_o.data.region == REGION_DISCARD) |->
      (out_o.data.status != STATUS_OK))
    else $error("discarded byte reported with ok status");
`endif

endmodule

`default_nettype wire

// ===== bench/rpfp_result_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the request packet field parser: follows the register writes,
// predicts the tagged byte and end-of-packet report for every accepted byte
// and compares each result transaction with it. Depends on rpfp_pkg.

module rpfp_result_checker
  import rpfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_item_t cfg_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        report_count_o
);

  localparam int LENGTH_BITS      = 32;
  localparam int SIZE_FIELD_BYTES = 8;

  phase_e      parse_phase;
  logic [3:0]  field_count;
  logic [31:0] byte_pos;
  logic [63:0] packet_total;
  logic [63:0] field_accum;
  logic [7:0]  opcode_seen;
  logic [63:0] name_len_seen;
  logic        type_seen;
  logic [63:0] first_len_seen;
  logic [63:0] region_left;
  status_e     first_error;
  logic [31:0] field_max;
  logic [7:0]  opcode_max;
  out_item_t   pending_results[$];
  out_item_t   want;
  int          fails;
  int          reports;

  function automatic void clear_packet();
    parse_phase    = PH_TOTAL;
    field_count    = '0;
    byte_pos       = '0;
    packet_total   = '0;
    field_accum    = '0;
    opcode_seen    = '0;
    name_len_seen  = '0;
    type_seen      = 1'b0;
    first_len_seen = '0;
    region_left    = '0;
    first_error    = STATUS_OK;
  endfunction

  function automatic void raise_error(input status_e code);
    if (first_error == STATUS_OK) begin
      first_error = code;
    end
    parse_phase = PH_DISCARD;
  endfunction

  function automatic logic take_field(input logic [7:0] b, output logic [63:0] v);
    field_accum = field_accum | (64'(b) << (field_count[2:0] * 8));
    field_count = field_count + 4'd1;
    v = field_accum;
    if (field_count >= SIZE_FIELD_BYTES) begin
      field_accum = '0;
      field_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [63:0] bytes_left();
    logic [63:0] next_pos;
    next_pos = 64'(byte_pos) + 64'd1;
    return (packet_total > next_pos) ? packet_total - next_pos : 64'd0;
  endfunction

  function automatic logic oversized(input logic [63:0] v);
    return (v >> LENGTH_BITS) != 64'd0;
  endfunction

  function automatic out_item_t parse_byte(input in_item_t item);
    out_item_t   res;
    logic [63:0] v;
    region_e     tag;
    status_e     st;
    res = '0;
    tag = REGION_HEADER;
    case (parse_phase)
      PH_TOTAL: begin
        if (take_field(item.data_byte, v)) begin
          if (oversized(v)) begin
            raise_error(STATUS_LEN_MISMATCH);
          end else begin
            packet_total = v;
            parse_phase  = PH_OPCODE;
          end
        end
      end
      PH_OPCODE: begin
        opcode_seen = item.data_byte;
        if (item.data_byte > opcode_max) begin
          raise_error(STATUS_BAD_OPCODE);
        end else begin
          parse_phase = PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        if (take_field(item.data_byte, v)) begin
          if (oversized(v)) begin
            raise_error(STATUS_LEN_MISMATCH);
          end else begin
            name_len_seen = v;
            if (v > 64'(field_max) || v >= bytes_left()) begin
              raise_error(STATUS_NAME_LONG);
            end else begin
              region_left = v;
              parse_phase = (v == 64'd0) ? PH_TYPE : PH_NAME;
            end
          end
        end
      end
      PH_NAME: begin
        tag = REGION_NAME;
        if (region_left != 64'd0) begin
          region_left = region_left - 64'd1;
        end
        if (region_left == 64'd0) begin
          parse_phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (item.data_byte > 8'd1) begin
          raise_error(STATUS_BAD_TYPE);
        end else begin
          type_seen = item.data_byte[0];
          if (item.data_byte[0]) begin
            parse_phase = PH_P1LEN;
          end else begin
            region_left = bytes_left();
            parse_phase = PH_REST;
          end
        end
      end
      PH_P1LEN: begin
        if (take_field(item.data_byte, v)) begin
          if (oversized(v)) begin
            raise_error(STATUS_LEN_MISMATCH);
          end else begin
            first_len_seen = v;
            if (v > 64'(field_max) || v >= bytes_left()) begin
              raise_error(STATUS_PAYLOAD_LONG);
            end else if (v == 64'd0) begin
              region_left = bytes_left();
              parse_phase = PH_REST;
            end else begin
              region_left = v;
              parse_phase = PH_P1;
            end
          end
        end
      end
      PH_P1: begin
        tag = REGION_FIRST;
        if (region_left != 64'd0) begin
          region_left = region_left - 64'd1;
        end
        if (region_left == 64'd0) begin
          region_left = bytes_left();
          parse_phase = PH_REST;
        end
      end
      PH_REST: begin
        tag = REGION_TRAILING;
      end
      default: begin
        tag = REGION_DISCARD;
      end
    endcase

    res.out_byte = item.data_byte;
    res.region   = tag;
    if (item.is_last) begin
      st = first_error;
      if (st == STATUS_OK &&
          (parse_phase != PH_REST || 64'(byte_pos) + 64'd1 != packet_total)) begin
        st = STATUS_LEN_MISMATCH;
      end
      res.report_valid = 1'b1;
      res.status       = st;
      res.opcode       = opcode_seen;
      res.name_length  = name_len_seen[31:0];
      res.two_payloads = type_seen;
      res.first_length = first_len_seen[31:0];
      res.rest_length  = (parse_phase == PH_REST) ? region_left[31:0] : 32'd0;
      clear_packet();
    end else if (byte_pos != '1) begin
      byte_pos = byte_pos + 32'd1;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, exp_val, act_val);
      fails++;
    end
  endtask

  task automatic compare_result(input out_item_t exp_res, input out_item_t act_res);
    check_field("out_byte", 32'(exp_res.out_byte), 32'(act_res.out_byte));
    check_field("region", 32'(exp_res.region), 32'(act_res.region));
    check_field("report_valid", 32'(exp_res.report_valid), 32'(act_res.report_valid));
    check_field("status", 32'(exp_res.status), 32'(act_res.status));
    check_field("opcode", 32'(exp_res.opcode), 32'(act_res.opcode));
    check_field("name_length", exp_res.name_length, act_res.name_length);
    check_field("two_payloads", 32'(exp_res.two_payloads), 32'(act_res.two_payloads));
    check_field("first_length", exp_res.first_length, act_res.first_length);
    check_field("rest_length", exp_res.rest_length, act_res.rest_length);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_packet();
      field_max  = MAX_FIELD_LENGTH_RST;
      opcode_max = MAX_OPCODE_RST;
      pending_results.delete();
      fails   = 0;
      reports = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      report_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.addr == CFG_MAX_FIELD_LENGTH) begin
          field_max = cfg_data_i.value;
        end else if (cfg_data_i.addr == CFG_MAX_OPCODE) begin
          opcode_max = cfg_data_i.value[7:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(parse_byte(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                   $time, out_data_i);
          fails++;
        end else begin
          want = pending_results.pop_front();
          compare_result(want, out_data_i);
          if (want.report_valid) begin
            reports++;
          end
        end
      end
      fail_count_o   <= fails;
      pending_o      <= pending_results.size();
      report_count_o <= reports;
    end
  end

endmodule

// ===== bench/tb_request_packet_field_parser_core.sv =====
`timescale 1ns / 1ps
// Top of the request packet field parser testbench: clock, reset, register
// writes and packet stimulus with random idling; checking is in
// rpfp_result_checker. Depends on rpfp_pkg, rpfp_stream_if and the core.

module tb_request_packet_field_parser_core;
  import rpfp_pkg::*;

  localparam int         ITEM_TARGET = 1450;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [7:0] CFG_SPARE   = 8'hA5;

  logic        clk_i;
  logic        rst_ni;
  int          idle_pct;
  int          cycles;
  int          packets;
  int          bytes_sent;
  int          writes;
  int          fail_count;
  int          pending;
  int          report_count;
  logic [31:0] cur_field_max;
  logic [7:0]  cur_opcode_max;
  logic [7:0]  pkt_q[$];

  rpfp_stream_if #(.T(in_item_t))  byte_if ();
  rpfp_stream_if #(.T(cfg_item_t)) cfg_if ();
  rpfp_stream_if #(.T(out_item_t)) result_if ();

  request_packet_field_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .cfg_i  (cfg_if),
    .out_o  (result_if)
  );

  rpfp_result_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (byte_if.valid),
    .in_ready_i     (byte_if.ready),
    .in_data_i      (byte_if.data),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_data_i     (cfg_if.data),
    .out_valid_i    (result_if.valid),
    .out_ready_i    (result_if.ready),
    .out_data_i     (result_if.data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .report_count_o (report_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timed out after %0d cycles", cycles);
    $display("tb_request_packet_field_parser_core: errors");
    $finish;
  end

  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) < idle_pct) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(0, 99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data  <= '{b, last};
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_queue(input int keep);
    int n;
    n = (keep == 0 || keep > pkt_q.size()) ? pkt_q.size() : keep;
    for (int i = 0; i < n; i++) begin
      send_byte(pkt_q[i], i == n - 1);
    end
    packets++;
  endtask

  task automatic push_le(input logic [63:0] v);
    for (int i = 0; i < 8; i++) begin
      pkt_q.push_back(v[8*i +: 8]);
    end
  endtask

  function automatic int body_len(input logic [63:0] n);
    return (n > 64'd64) ? 64 : int'(n);
  endfunction

  // Lay out one request; delta skews the declared total, keep cuts it short.
  task automatic packet(input logic [7:0] opc, input logic [63:0] nlen,
                        input logic [7:0] typ, input logic [63:0] p1, input int rlen,
                        input longint delta, input int keep);
    logic [63:0] total;
    total = 64'd18 + nlen + ((typ == 8'd1) ? 64'd8 + p1 : 64'd0) + 64'(rlen) + delta;
    pkt_q.delete();
    push_le(total);
    pkt_q.push_back(opc);
    push_le(nlen);
    repeat (body_len(nlen)) pkt_q.push_back(8'($urandom));
    pkt_q.push_back(typ);
    if (typ == 8'd1) begin
      push_le(p1);
      repeat (body_len(p1)) pkt_q.push_back(8'($urandom));
    end
    repeat (rlen) pkt_q.push_back(8'($urandom));
    send_queue(keep);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_MAX_FIELD_LENGTH) begin
      cur_field_max = val;
    end else if (idx == CFG_MAX_OPCODE) begin
      cur_opcode_max = val[7:0];
    end
    writes++;
  endtask

  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      write_reg(CFG_MAX_FIELD_LENGTH, $urandom_range(0, 6));
    end else if (pick == 1) begin
      write_reg(CFG_MAX_FIELD_LENGTH, $urandom);
    end else if (pick == 2) begin
      write_reg(CFG_MAX_FIELD_LENGTH, '1);
    end else begin
      write_reg(CFG_MAX_FIELD_LENGTH, $urandom_range(8, 5000));
    end
    pick = $urandom_range(0, 3);
    if (pick == 0) begin
      write_reg(CFG_MAX_OPCODE, $urandom);
    end else if (pick == 1) begin
      write_reg(CFG_MAX_OPCODE, 32'd255);
    end else begin
      write_reg(CFG_MAX_OPCODE, $urandom_range(0, 20));
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg(8'($urandom_range(CFG_MAX_OPCODE + 1, 255)), $urandom);
    end
  endtask

  // Mostly well-formed requests; the rest break one field, the total or the end, or send random bytes.
  task automatic random_packet();
    int          kind;
    logic [7:0]  opc;
    logic [63:0] nlen;
    logic [7:0]  typ;
    logic [63:0] p1;
    int          rlen;
    longint      delta;
    int          keep;
    kind  = $urandom_range(0, 19);
    opc   = 8'($urandom_range(0, int'(cur_opcode_max)));
    nlen  = 64'($urandom_range(0, 6));
    typ   = 8'($urandom_range(0, 1));
    p1    = 64'($urandom_range(0, 6));
    rlen  = $urandom_range((p1 != 64'd0) ? 1 : 0, 8);
    delta = 0;
    keep  = 0;
    if (kind == 13) begin
      opc = 8'($urandom);
    end else if (kind == 14) begin
      typ = 8'($urandom);
    end else if (kind == 15) begin
      if ($urandom_range(0, 1) == 0) begin
        nlen = 64'(cur_field_max) + 64'($urandom_range(0, 1));
      end else begin
        typ = 8'd1;
        p1  = 64'(cur_field_max) + 64'($urandom_range(0, 1));
      end
    end else if (kind == 16) begin
      delta = longint'($urandom_range(0, 6)) - 3;
    end else if (kind == 17) begin
      keep = $urandom_range(1, 40);
    end else if (kind == 18) begin
      case ($urandom_range(0, 2))
        0: delta = longint'(64'd1 << $urandom_range(32, 63));
        1: nlen = nlen | (64'd1 << $urandom_range(32, 63));
        default: begin
          typ = 8'd1;
          p1  = p1 | (64'd1 << $urandom_range(32, 63));
        end
      endcase
    end
    if (kind == 19) begin
      pkt_q.delete();
      repeat ($urandom_range(1, 24)) pkt_q.push_back(8'($urandom));
      send_queue(0);
    end else begin
      packet(opc, nlen, typ, p1, rlen, delta, keep);
    end
  endtask

  initial begin
    int phase_end;
    rst_ni         <= 1'b0;
    byte_if.valid  <= 1'b0;
    byte_if.data   <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.data    <= '0;
    idle_pct       = 0;
    packets        = 0;
    bytes_sent     = 0;
    writes         = 0;
    cur_field_max  = MAX_FIELD_LENGTH_RST;
    cur_opcode_max = MAX_OPCODE_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    packet(8'd0, 0, 8'd0, 0, 0, 0, 0);
    packet(8'd9, 2, 8'd1, 1, 1, 0, 0);
    packet(8'd10, 0, 8'd0, 0, 1, 0, 0);
    packet(8'hFF, 0, 8'd0, 0, 0, 0, 0);
    packet(8'd3, 0, 8'd0, 0, 2, 64'h1_0000_0000, 0);
    packet(8'd3, 4097, 8'd0, 0, 1, 0, 0);
    packet(8'd3, 3, 8'd0, 0, 0, -2, 0);
    packet(8'd3, 0, 8'd0, 0, 0, -10, 0);
    packet(8'd3, 1, 8'd2, 0, 1, 0, 0);
    packet(8'd3, 0, 8'hFF, 0, 1, 0, 0);
    packet(8'd3, 0, 8'd1, 5000, 1, 0, 0);
    packet(8'd3, 0, 8'd1, 2, 0, 0, 0);
    packet(8'd3, 0, 8'd1, 0, 3, 0, 0);
    packet(8'd3, 64'h1_0000_0001, 8'd0, 0, 1, 0, 0);
    packet(8'd3, 0, 8'd1, 64'h2_0000_0000, 1, 0, 0);
    packet(8'd3, 2, 8'd0, 0, 4, 0, 5);
    packet(8'd3, 4, 8'd0, 0, 4, 0, 19);
    packet(8'd3, 0, 8'd0, 0, 4, 3, 0);
    packet(8'd3, 0, 8'd0, 0, 4, -1, 0);

    wait_idle();
    write_reg(CFG_MAX_FIELD_LENGTH, '0);
    write_reg(CFG_MAX_OPCODE, '0);
    write_reg(CFG_SPARE, '1);
    packet(8'd0, 0, 8'd0, 0, 2, 0, 0);
    packet(8'd0, 1, 8'd0, 0, 2, 0, 0);
    packet(8'd1, 0, 8'd0, 0, 2, 0, 0);
    packet(8'd0, 0, 8'd1, 0, 2, 0, 0);
    packet(8'd0, 0, 8'd1, 1, 2, 0, 0);

    wait_idle();
    write_reg(CFG_MAX_FIELD_LENGTH, '1);
    write_reg(CFG_MAX_OPCODE, '1);
    packet(8'hFF, 3, 8'd1, 2, 2, 0, 0);
    packet(8'hFF, 64'hFFFF_FFFF, 8'd0, 0, 1, 0, 0);
    packet(8'hFF, 0, 8'd1, 64'hFFFF_FFFF, 1, 0, 0);

    while (bytes_sent < ITEM_TARGET) begin
      wait_idle();
      random_config();
      idle_pct  = (bytes_sent > ITEM_TARGET * 85 / 100) ? 0 : 15 * $urandom_range(0, 2);
      phase_end = bytes_sent + $urandom_range(80, 200);
      while (bytes_sent < phase_end && bytes_sent < ITEM_TARGET) begin
        if (bytes_sent > ITEM_TARGET * 85 / 100) begin
          idle_pct = 0;
        end
        random_packet();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d packets in %0d bytes with %0d end-of-packet reports,",
             packets, bytes_sent, report_count);
    $display("under %0d register writes including both limits at their extremes", writes);
    if (fail_count == 0) begin
      $display("tb_request_packet_field_parser_core: clean");
    end else begin
      $display("tb_request_packet_field_parser_core: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rpfp_pkg.sv
rtl/rpfp_stream_if.sv
rtl/rpfp_queue.sv
rtl/rpfp_back.sv
rtl/request_packet_field_parser_core.sv
bench/rpfp_result_checker.sv
bench/tb_request_packet_field_parser_core.sv
